// File: rtl/blr_pkg.sv
// ----------------------------------------------------------------------------
// blr_pkg: shared types and constants of the line rasterizer
// Payload structures of the input and output channels and the action codes.
// ----------------------------------------------------------------------------
package blr_pkg;

    localparam int COORD_W = 16;
    localparam int COLOR_W = 32;
    localparam int PIX_W   = 10;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef struct packed {
        logic                      action;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic        [COLOR_W-1:0] start_color;
        logic        [COLOR_W-1:0] end_color;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               last_pixel;
    } t_out_item;

endpackage

// File: rtl/blr_in_if.sv
// ----------------------------------------------------------------------------
// blr_in_if: input channel of the line rasterizer
// Valid/ready channel carrying load and step transactions.
// ----------------------------------------------------------------------------
interface blr_in_if;
    import blr_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/blr_out_if.sv
// ----------------------------------------------------------------------------
// blr_out_if: output channel of the line rasterizer
// Valid/ready channel carrying one pixel per transaction.
// ----------------------------------------------------------------------------
interface blr_out_if;
    import blr_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer: Bresenham line walker, one pixel per step
// A load transaction on i_in sets up a line between two signed endpoints.
// Each step transaction on i_in then yields one pixel transaction on o_out,
// walking the major axis by one pixel under a Bresenham error term. The far
// endpoint is not drawn, and last_pixel marks the final pixel of a line.
// The color switches from the lower-major endpoint's color to the other's past the middle
// of the major axis. Coordinates are clamped to the screen on output only.
// A pixel is registered and appears on o_out in the cycle after its step. One
// transaction is taken per cycle, set by the single output register: input
// is ready whenever that register is empty or is being read in the same
// cycle. When the receiver stalls, the pixel holds and input stops.
// Load transactions and steps while no line is active produce no pixel.
// A load replaces any line in progress. After reset the block is idle.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 1024
) (
    input logic       i_clk,
    input logic       i_rst_n,
    blr_in_if.sink    i_in,
    blr_out_if.source o_out
);
    import blr_pkg::*;

    localparam logic signed [17:0] WIDTH_S  = 18'(SCREEN_WIDTH);
    localparam logic signed [17:0] HEIGHT_S = 18'(SCREEN_HEIGHT);

    function automatic logic [PIX_W-1:0] clamp_axis(
        input logic signed [16:0] v,
        input logic signed [17:0] size
    );
        logic signed [17:0] w;
        logic signed [17:0] c;
        w = 18'(v);
        if (w < 0) begin
            c = '0;
        end else if (w >= size) begin
            c = size - 18'sd1;
        end else begin
            c = w;
        end
        return c[PIX_W-1:0];
    endfunction

    logic                      r_busy;
    logic                      r_steep;
    logic signed [COORD_W-1:0] r_major_pos;
    logic signed [16:0]        r_minor_pos;
    logic signed [COORD_W-1:0] r_major_end;
    logic signed [16:0]        r_major_mid;
    logic                      r_minor_neg;
    logic signed [16:0]        r_delta_major;
    logic signed [16:0]        r_delta_minor;
    logic signed [19:0]        r_error;
    logic        [COLOR_W-1:0] r_cur_color;
    logic        [COLOR_W-1:0] r_fin_color;
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic                      n_busy;
    logic                      n_steep;
    logic signed [COORD_W-1:0] n_major_pos;
    logic signed [16:0]        n_minor_pos;
    logic signed [COORD_W-1:0] n_major_end;
    logic signed [16:0]        n_major_mid;
    logic                      n_minor_neg;
    logic signed [16:0]        n_delta_major;
    logic signed [16:0]        n_delta_minor;
    logic signed [19:0]        n_error;
    logic        [COLOR_W-1:0] n_cur_color;
    logic        [COLOR_W-1:0] n_fin_color;
    logic                      n_out_valid;
    t_out_item                 n_out;

    logic                      w_ready;
    logic                      w_accept;
    logic                      w_emit;

    logic signed [16:0]        w_dx;
    logic signed [16:0]        w_dy;
    logic signed [16:0]        w_adx;
    logic signed [16:0]        w_ady;
    logic                      w_steep;
    logic signed [COORD_W-1:0] w_amaj;
    logic signed [COORD_W-1:0] w_amin;
    logic signed [COORD_W-1:0] w_bmaj;
    logic signed [COORD_W-1:0] w_bmin;
    logic        [COLOR_W-1:0] w_acol;
    logic        [COLOR_W-1:0] w_bcol;
    logic                      w_swap;
    logic signed [16:0]        w_dmin;
    logic signed [16:0]        w_dmaj;

    logic signed [16:0]        w_major_ext;
    logic signed [16:0]        w_major_inc;
    logic signed [16:0]        w_px;
    logic signed [16:0]        w_py;

    assign w_ready  = !r_out_valid || o_out.ready;
    assign w_accept = i_in.valid && w_ready;
    assign w_emit   = w_accept && (i_in.data.action == ACT_STEP) && r_busy;

    assign i_in.ready  = w_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        w_dx    = 17'(i_in.data.end_x) - 17'(i_in.data.start_x);
        w_dy    = 17'(i_in.data.end_y) - 17'(i_in.data.start_y);
        w_adx   = (w_dx < 0) ? -w_dx : w_dx;
        w_ady   = (w_dy < 0) ? -w_dy : w_dy;
        w_steep = !(w_ady < w_adx);
        w_swap  = w_steep ? (i_in.data.start_y > i_in.data.end_y)
                          : (i_in.data.start_x > i_in.data.end_x);
        if (w_steep) begin
            w_amaj = w_swap ? i_in.data.end_y : i_in.data.start_y;
            w_bmaj = w_swap ? i_in.data.start_y : i_in.data.end_y;
            w_amin = w_swap ? i_in.data.end_x : i_in.data.start_x;
            w_bmin = w_swap ? i_in.data.start_x : i_in.data.end_x;
        end else begin
            w_amaj = w_swap ? i_in.data.end_x : i_in.data.start_x;
            w_bmaj = w_swap ? i_in.data.start_x : i_in.data.end_x;
            w_amin = w_swap ? i_in.data.end_y : i_in.data.start_y;
            w_bmin = w_swap ? i_in.data.start_y : i_in.data.end_y;
        end
        w_acol = w_swap ? i_in.data.end_color : i_in.data.start_color;
        w_bcol = w_swap ? i_in.data.start_color : i_in.data.end_color;
        w_dmin = 17'(w_bmin) - 17'(w_amin);
        w_dmaj = 17'(w_bmaj) - 17'(w_amaj);

        w_major_ext = 17'(r_major_pos);
        w_major_inc = w_major_ext + 17'sd1;
        w_px = r_steep ? r_minor_pos : w_major_ext;
        w_py = r_steep ? w_major_ext : r_minor_pos;
    end

    always_comb begin
        n_busy        = r_busy;
        n_steep       = r_steep;
        n_major_pos   = r_major_pos;
        n_minor_pos   = r_minor_pos;
        n_major_end   = r_major_end;
        n_major_mid   = r_major_mid;
        n_minor_neg   = r_minor_neg;
        n_delta_major = r_delta_major;
        n_delta_minor = r_delta_minor;
        n_error       = r_error;
        n_cur_color   = r_cur_color;
        n_fin_color   = r_fin_color;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out         = r_out;

        if (w_accept && (i_in.data.action == ACT_LOAD)) begin
            n_steep       = w_steep;
            n_minor_neg   = (w_dmin < 0);
            n_delta_minor = (w_dmin < 0) ? -w_dmin : w_dmin;
            n_delta_major = w_dmaj;
            n_major_pos   = w_amaj;
            n_minor_pos   = 17'(w_amin);
            n_major_end   = w_bmaj;
            n_major_mid   = 17'(w_amaj) + (w_dmaj >>> 1);
            n_error       = (20'(n_delta_minor) <<< 1) - 20'(w_dmaj);
            n_cur_color   = w_acol;
            n_fin_color   = w_bcol;
            n_busy        = (w_dmaj > 0);
        end else if (w_emit) begin
            n_out_valid       = 1'b1;
            n_out.pixel_x     = clamp_axis(w_px, WIDTH_S);
            n_out.pixel_y     = clamp_axis(w_py, HEIGHT_S);
            n_out.pixel_color = r_cur_color;
            n_out.last_pixel  = (w_major_inc >= 17'(r_major_end));
            if (r_error > 0) begin
                n_minor_pos = r_minor_pos + (r_minor_neg ? -17'sd1 : 17'sd1);
                n_error     = r_error + ((20'(r_delta_minor) - 20'(r_delta_major)) <<< 1);
            end else begin
                n_error     = r_error + (20'(r_delta_minor) <<< 1);
            end
            n_major_pos = w_major_inc[COORD_W-1:0];
            if (w_major_inc > r_major_mid) begin
                n_cur_color = r_fin_color;
            end
            if (w_major_inc >= 17'(r_major_end)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_steep       <= n_steep;
        r_major_pos   <= n_major_pos;
        r_minor_pos   <= n_minor_pos;
        r_major_end   <= n_major_end;
        r_major_mid   <= n_major_mid;
        r_minor_neg   <= n_minor_neg;
        r_delta_major <= n_delta_major;
        r_delta_minor <= n_delta_minor;
        r_error       <= n_error;
        r_cur_color   <= n_cur_color;
        r_fin_color   <= n_fin_color;
        r_out         <= n_out;
    end

    a_busy_before_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_major_pos < r_major_end))
        else $error("Active line has reached its far endpoint.");

    a_minor_not_major : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_delta_minor <= r_delta_major))
        else $error("Minor delta exceeds major delta.");

    a_last_ends_line : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && (w_major_inc >= 17'(r_major_end))) |=> !r_busy)
        else $error("Line still active after its last pixel.");

    a_load_no_pixel : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.data.action == ACT_LOAD)) |=> !$rose(r_out_valid))
        else $error("Load transaction produced a pixel.");

    a_idle_step_no_pixel : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !r_busy && !r_out_valid) |=> !r_out_valid)
        else $error("Step while idle produced a pixel.");

endmodule
